[hdl/rbi_pkg.sv]
`timescale 1ns / 1ps

package rbi_pkg;

    // Default queue depths.
    localparam int RBI_RAY_DEPTH = 2;
    localparam int RBI_RES_DEPTH = 4;

    // Fixed-point widths.
    localparam int Q_W     = 32;
    localparam int FRAC_W  = 16;
    localparam int EPS_W   = 16;
    localparam int SIZE_W  = 31;
    localparam int CFG_W   = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_W-1:0] {
        CFG_MIN_X      = 3'd0,
        CFG_MIN_Y      = 3'd1,
        CFG_MIN_Z      = 3'd2,
        CFG_SIZE_X     = 3'd3,
        CFG_SIZE_Y     = 3'd4,
        CFG_SIZE_Z     = 3'd5,
        CFG_TOLERANCE  = 3'd6,
        CFG_REPORT_ALL = 3'd7
    } t_cfg_idx;

    // Face codes.
    localparam logic [2:0] FACE_PZ = 3'd0;
    localparam logic [2:0] FACE_NZ = 3'd1;
    localparam logic [2:0] FACE_NX = 3'd2;
    localparam logic [2:0] FACE_PX = 3'd3;
    localparam logic [2:0] FACE_PY = 3'd4;
    localparam logic [2:0] FACE_NY = 3'd5;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // One classified ray as it travels from the front to the back.
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [2:0][32:0] lo;
        logic [2:0][32:0] hi;
        logic [2:0][33:0] lo_w;
        logic [2:0][33:0] hi_w;
        logic [2:0]       usable;
        logic             in_box;
        logic             all;
        logic [15:0]      eps;
    } t_ray;

    // One result item.
    typedef struct packed {
        logic             hit;
        logic [30:0]      distance;
        logic [2:0][31:0] pt;
        logic [2:0]       face;
        logic             last;
    } t_result;

    // Axis that a face lies across.
    function automatic logic [1:0] face_axis(input logic [2:0] f);
        logic [1:0] a;
        case (f)
            FACE_PZ, FACE_NZ: a = AXIS_Z;
            FACE_NX, FACE_PX: a = AXIS_X;
            default:          a = AXIS_Y;
        endcase
        return a;
    endfunction

    // Whether a face sits on the maximum side of the box.
    function automatic logic face_is_max(input logic [2:0] f);
        return (f == FACE_PZ) || (f == FACE_PX) || (f == FACE_PY);
    endfunction

    // Axis visited at step i of the nearest search (z, x, y).
    function automatic logic [1:0] near_axis(input logic [2:0] i);
        logic [1:0] a;
        case (i)
            3'd0:    a = AXIS_Z;
            3'd1:    a = AXIS_X;
            default: a = AXIS_Y;
        endcase
        return a;
    endfunction

    // Candidate face on an axis for the nearest search.
    function automatic logic [2:0] near_face(input logic [1:0] a, input logic use_max);
        logic [2:0] f;
        case (a)
            AXIS_Z:  f = use_max ? FACE_PZ : FACE_NZ;
            AXIS_X:  f = use_max ? FACE_PX : FACE_NX;
            default: f = use_max ? FACE_PY : FACE_NY;
        endcase
        return f;
    endfunction

endpackage

[hdl/ray_box_intersection_core.sv]
`timescale 1ns / 1ps

// Ray against axis-aligned box test in signed Q16.16. Rays enter through a
// push/full queue port, results leave through an empty/pop queue port. A
// front stage classifies each ray against the configured box and queues it;
// a back stage works one ray at a time through a shared divider that yields
// one quotient bit per cycle, so the divider sets the rate. In nearest mode the
// back stage divides once for each usable axis and skips the others; in
// all-hits mode it divides once for each face on a usable axis. A full result
// queue stalls the back stage.
// Configuration writes are taken every cycle and apply to rays accepted
// afterwards.
module ray_box_intersection_core
    import rbi_pkg::*;
#(
    parameter int RAY_DEPTH = RBI_RAY_DEPTH,
    parameter int RES_DEPTH = RBI_RES_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    output logic               empty,
    input  logic               pop,
    output logic               o_hit,
    output logic [30:0]        o_distance,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic [2:0]         o_face,
    output logic               o_last
);

    t_ray    front_ray, back_ray;
    t_result res_in, res_out;
    logic    ray_empty, ray_pop, res_push, res_full;

    rbi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_origin_z  (i_origin_z),
        .i_dir_x     (i_dir_x),
        .i_dir_y     (i_dir_y),
        .i_dir_z     (i_dir_z),
        .o_ray       (front_ray)
    );

    rbi_fifo #(.W($bits(t_ray)), .DEPTH(RAY_DEPTH)) u_ray_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_ray),
        .o_full    (full),
        .i_rd      (ray_pop),
        .o_rd_data (back_ray),
        .o_empty   (ray_empty)
    );

    rbi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray       (back_ray),
        .i_ray_empty (ray_empty),
        .o_ray_pop   (ray_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    rbi_fifo #(.W($bits(t_result)), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_push),
        .i_wr_data (res_in),
        .o_full    (res_full),
        .i_rd      (pop),
        .o_rd_data (res_out),
        .o_empty   (empty)
    );

    assign o_hit      = res_out.hit;
    assign o_distance = res_out.distance;
    assign o_point_x  = res_out.pt[0];
    assign o_point_y  = res_out.pt[1];
    assign o_point_z  = res_out.pt[2];
    assign o_face     = res_out.face;
    assign o_last     = res_out.last;

endmodule

[hdl/rbi_fifo.sv]
`timescale 1ns / 1ps

module rbi_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wr_data,
    output logic         o_full,
    input  logic         i_rd,
    output logic [W-1:0] o_rd_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_ok, rd_ok;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rptr];
    assign wr_ok     = i_wr && !o_full;
    assign rd_ok     = i_rd && !o_empty;

    // Pointer and count updates, wrapping at the depth.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_ok) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_ok) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_count = r_count + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_ok && !rd_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule

[hdl/rbi_front.sv]
`timescale 1ns / 1ps

module rbi_front
    import rbi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    output t_ray              o_ray
);

    logic [2:0][31:0]     r_min;
    logic [2:0][SIZE_W-1:0] r_size;
    logic [EPS_W-1:0]     r_eps;
    logic                 r_all;
    logic [2:0][31:0]     org, dir;
    logic                 org_in_box;

    assign o_cfg_ready = 1'b1;
    assign org = {i_origin_z, i_origin_y, i_origin_x};
    assign dir = {i_dir_z, i_dir_y, i_dir_x};

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_size <= {3{SIZE_W'(32'h0001_0000)}};
            r_eps  <= EPS_W'(1);
            r_all  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_X:      r_min[0]  <= i_cfg_data;
                CFG_MIN_Y:      r_min[1]  <= i_cfg_data;
                CFG_MIN_Z:      r_min[2]  <= i_cfg_data;
                CFG_SIZE_X:     r_size[0] <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:     r_size[1] <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:     r_size[2] <= i_cfg_data[SIZE_W-1:0];
                CFG_TOLERANCE:  r_eps     <= i_cfg_data[EPS_W-1:0];
                CFG_REPORT_ALL: r_all     <= i_cfg_data[0];
                default:        r_all     <= r_all;
            endcase
        end
    end

    // Classify the ray: box planes, widened bounds, usable axes, inside test.
    always_comb begin
        o_ray = '0;
        org_in_box = 1'b1;
        for (int k = 0; k < 3; k++) begin
            o_ray.org[k]  = org[k];
            o_ray.dir[k]  = dir[k];
            o_ray.lo[k]   = {r_min[k][31], r_min[k]};
            o_ray.hi[k]   = $signed({r_min[k][31], r_min[k]}) + $signed({2'b00, r_size[k]});
            o_ray.lo_w[k] = $signed({{2{r_min[k][31]}}, r_min[k]})
                          - $signed({18'b0, r_eps});
            o_ray.hi_w[k] = $signed({o_ray.hi[k][32], o_ray.hi[k]})
                          + $signed({18'b0, r_eps});
            o_ray.usable[k] = ($signed({dir[k][31], dir[k]}) > $signed({17'b0, r_eps}))
                           || ($signed({dir[k][31], dir[k]}) < -$signed({17'b0, r_eps}));
            if (($signed({org[k][31], org[k]}) < $signed(o_ray.lo[k]))
                || ($signed({org[k][31], org[k]}) > $signed(o_ray.hi[k]))) begin
                org_in_box = 1'b0;
            end
        end
        o_ray.in_box = org_in_box;
        o_ray.all    = r_all;
        o_ray.eps    = r_eps;
    end

endmodule

[hdl/rbi_div.sv]
`timescale 1ns / 1ps

module rbi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [49:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic [31:0] r_rem, r_q;
    logic [5:0]  r_cnt;
    logic        r_neg, r_ovf, r_done;
    logic [49:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] r_den;
    logic [17:0] high;
    logic [32:0] trial;
    logic        ge;

    // Magnitudes and the overflow check on the high dividend bits.
    assign mag_n = i_num[49] ? (50'd0 - i_num) : i_num;
    assign mag_d = i_den[31] ? (32'd0 - i_den) : i_den;
    assign high  = mag_n[49:32];

    // One quotient bit per cycle, restoring.
    assign trial = {r_rem, r_q[31]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (i_start) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {14'b0, high};
            r_q   <= mag_n[31:0];
            r_den <= mag_d;
            r_neg <= i_num[49] ^ i_den[31];
            r_ovf <= ({14'b0, high} >= mag_d);
        end else if (r_cnt != '0) begin
            r_rem <= ge ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_q   <= {r_q[30:0], ge};
        end
    end

    // Saturate the signed quotient to 32 bits.
    always_comb begin
        if (r_neg) begin
            o_quot = (r_ovf || (r_q > 32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - r_q);
        end else begin
            o_quot = (r_ovf || r_q[31]) ? 32'h7FFF_FFFF : r_q;
        end
    end

    assign o_done = r_done;

endmodule

[hdl/rbi_back.sv]
`timescale 1ns / 1ps

module rbi_back
    import rbi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ray    i_ray,
    input  logic    i_ray_empty,
    output logic    o_ray_pop,
    output logic    o_res_push,
    output t_result o_res,
    input  logic    i_res_full
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_NEXT   = 7'b0000010,
        S_DSTART = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_PT     = 7'b0100000,
        S_CHK    = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    t_ray        r_ray, n_ray;
    logic [2:0]  r_idx, n_idx;
    logic        r_have, n_have;
    logic [31:0] r_best_t, n_best_t;
    logic [2:0]  r_best_f, n_best_f;
    logic [2:0]  r_cur_f, n_cur_f;
    logic [31:0] r_t, n_t;
    logic [49:0] r_num, n_num;
    logic [31:0] r_den, n_den;
    logic        r_pend_v, n_pend_v;
    t_result     r_pend, n_pend;
    logic [2:0][63:0] r_prod;
    logic [2:0][48:0] r_pt;

    logic        div_start, div_done;
    logic [31:0] div_t;
    logic [2:0]  lim, sel_f;
    logic [1:0]  sel_a, cur_a;
    logic [32:0] plane;
    logic [33:0] diff;
    logic        pass;
    t_result     cur_res, miss_res;

    function automatic logic [31:0] sat32(input logic [48:0] v);
        logic [31:0] s;
        if ($signed(v) > $signed(49'sh0_7FFF_FFFF)) begin
            s = 32'h7FFF_FFFF;
        end else if ($signed(v) < -$signed(49'sh0_8000_0000)) begin
            s = 32'h8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    rbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_t)
    );

    // Face under consideration at this step and its plane offset.
    always_comb begin
        lim   = r_ray.all ? 3'd6 : 3'd3;
        sel_a = r_ray.all ? face_axis(r_idx) : near_axis(r_idx);
        sel_f = r_ray.all ? r_idx
              : near_face(sel_a, r_ray.in_box ? !r_ray.dir[sel_a][31]
                                              : r_ray.dir[sel_a][31]);
        plane = face_is_max(sel_f) ? r_ray.hi[sel_a] : r_ray.lo[sel_a];
        diff  = $signed({plane[32], plane}) - $signed({{2{r_ray.org[sel_a][31]}},
                                                       r_ray.org[sel_a]});
    end

    // Distance and bounds test on the computed hit point.
    always_comb begin
        cur_a = face_axis(r_cur_f);
        pass  = $signed({1'b0, r_t}) > $signed({17'b0, r_ray.eps})
              && !r_t[31];
        for (int k = 0; k < 3; k++) begin
            if (2'(k) != cur_a) begin
                if (!($signed(r_pt[k]) > $signed({{15{r_ray.lo_w[k][33]}}, r_ray.lo_w[k]})
                      && $signed(r_pt[k]) < $signed({{15{r_ray.hi_w[k][33]}},
                                                     r_ray.hi_w[k]}))) begin
                    pass = 1'b0;
                end
            end
        end
        cur_res          = '0;
        cur_res.hit      = 1'b1;
        cur_res.distance = r_t[30:0];
        for (int k = 0; k < 3; k++) begin
            cur_res.pt[k] = sat32(r_pt[k]);
        end
        cur_res.face = r_cur_f;
        miss_res      = '0;
        miss_res.last = 1'b1;
    end

    // Sequencer over the candidate faces of one ray.
    always_comb begin
        n_state  = r_state;
        n_ray    = r_ray;
        n_idx    = r_idx;
        n_have   = r_have;
        n_best_t = r_best_t;
        n_best_f = r_best_f;
        n_cur_f  = r_cur_f;
        n_t      = r_t;
        n_num    = r_num;
        n_den    = r_den;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        o_ray_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = miss_res;
        div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_ray_empty) begin
                    o_ray_pop = 1'b1;
                    n_ray     = i_ray;
                    n_idx     = '0;
                    n_have    = 1'b0;
                    n_pend_v  = 1'b0;
                    n_state   = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_idx == lim) begin
                    if (r_ray.all) begin
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_res      = r_pend_v ? r_pend : miss_res;
                            o_res.last = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end else if (r_have) begin
                        n_cur_f = r_best_f;
                        n_t     = r_best_t;
                        n_state = S_MUL;
                    end else if (!i_res_full) begin
                        o_res_push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (!r_ray.usable[sel_a]) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_cur_f = sel_f;
                    n_num   = {diff, 16'b0};
                    n_den   = r_ray.dir[sel_a];
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_ray.all) begin
                        n_t     = div_t;
                        n_state = S_MUL;
                    end else begin
                        if (!r_have || (r_ray.in_box ? ($signed(div_t) < $signed(r_best_t))
                                                     : ($signed(div_t) > $signed(r_best_t))))
                        begin
                            n_best_t = div_t;
                            n_best_f = r_cur_f;
                            n_have   = 1'b1;
                        end
                        n_idx   = r_idx + 1'b1;
                        n_state = S_NEXT;
                    end
                end
            end
            S_MUL: begin
                n_state = S_PT;
            end
            S_PT: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_ray.all) begin
                    if (!pass) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_NEXT;
                    end else if (!r_pend_v) begin
                        n_pend   = cur_res;
                        n_pend_v = 1'b1;
                        n_idx    = r_idx + 1'b1;
                        n_state  = S_NEXT;
                    end else if (!i_res_full) begin
                        // An earlier hit is known not to be the last one.
                        o_res_push = 1'b1;
                        o_res      = r_pend;
                        n_pend     = cur_res;
                        n_idx      = r_idx + 1'b1;
                        n_state    = S_NEXT;
                    end
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = pass ? cur_res : miss_res;
                    o_res.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_have   <= 1'b0;
            r_pend_v <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_have   <= n_have;
            r_pend_v <= n_pend_v;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ray    <= n_ray;
        r_best_t <= n_best_t;
        r_best_f <= n_best_f;
        r_cur_f  <= n_cur_f;
        r_t      <= n_t;
        r_num    <= n_num;
        r_den    <= n_den;
        r_pend   <= n_pend;
    end

    // Hit point: product, then floor shift and origin add.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (r_state == S_MUL) begin
                r_prod[k] <= $signed(r_ray.dir[k]) * $signed(r_t);
            end
            if (r_state == S_PT) begin
                r_pt[k] <= $signed({{17{r_ray.org[k][31]}}, r_ray.org[k]})
                         + $signed({r_prod[k][63], r_prod[k][63:16]});
            end
        end
    end

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result written into a full queue");

    a_last_nearest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && !o_res.last) |-> r_ray.all)
        else $error("non-final result outside all-hits mode");

endmodule
